/* rtl/jbpg_pkg.sv */
// Package for the jittered Bezier path generator: shared widths, constants,
// command codes and the controller/datapath command and status structs.
// No dependencies.
package jbpg_pkg;

  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned OFS_W   = 26;
  localparam int unsigned WGT_W   = 33;
  localparam int unsigned TOT_W   = 39;
  localparam int unsigned D3_W    = 36;
  localparam int unsigned MA_W    = 72;
  localparam int unsigned MB_W    = 64;
  localparam int unsigned REM_W   = 40;
  localparam int unsigned QUO_W   = 32;

  localparam int          BOX_MARGIN = 80 * 256;
  localparam logic [9:0]  MS_TO_US   = 10'd1000;

  localparam logic [63:0] SM_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SM_MIX1  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] SM_MIX2  = 64'h94D049BB133111EB;

  localparam logic [CFG_W-1:0] MIN_MS_RST = 16'd100;
  localparam logic [CFG_W-1:0] MAX_MS_RST = 16'd300;

  localparam logic CFG_MIN_IDX = 1'b0;
  localparam logic CFG_MAX_IDX = 1'b1;

  localparam logic [4:0] OP_NOP  = 5'd0;
  localparam logic [4:0] OP_LOAD = 5'd1;
  localparam logic [4:0] OP_MIX0 = 5'd2;
  localparam logic [4:0] OP_MIX1 = 5'd3;
  localparam logic [4:0] OP_MIX2 = 5'd4;
  localparam logic [4:0] OP_SPAN = 5'd5;
  localparam logic [4:0] OP_CPW  = 5'd6;
  localparam logic [4:0] OP_DUR0 = 5'd7;
  localparam logic [4:0] OP_DUR1 = 5'd8;
  localparam logic [4:0] OP_WGT  = 5'd9;
  localparam logic [4:0] OP_DEN0 = 5'd10;
  localparam logic [4:0] OP_DEN1 = 5'd11;
  localparam logic [4:0] OP_DEN2 = 5'd12;
  localparam logic [4:0] OP_B0   = 5'd13;
  localparam logic [4:0] OP_B1   = 5'd14;
  localparam logic [4:0] OP_B2   = 5'd15;
  localparam logic [4:0] OP_B3   = 5'd16;
  localparam logic [4:0] OP_B4   = 5'd17;
  localparam logic [4:0] OP_B5   = 5'd18;
  localparam logic [4:0] OP_B6   = 5'd19;
  localparam logic [4:0] OP_SUM  = 5'd20;
  localparam logic [4:0] OP_DIVB = 5'd21;
  localparam logic [4:0] OP_PSTO = 5'd22;
  localparam logic [4:0] OP_OMUL = 5'd23;
  localparam logic [4:0] OP_ODIV = 5'd24;
  localparam logic [4:0] OP_OADD = 5'd25;
  localparam logic [4:0] OP_EMIT = 5'd26;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] sel;
    logic       axis;
  } cmd_t;

  typedef struct packed {
    logic idle;
    logic out_free;
    logic i_zero;
    logic i_last;
    logic j_last;
  } sts_t;

endpackage

/* rtl/jbpg_if.sv */
// Request and point channel interfaces for the path generator.
// Depends on jbpg_pkg for field widths.
interface jbpg_req_if #(parameter int COORD_WIDTH = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic [jbpg_pkg::IDX_W-1:0]    step_count;
  logic [63:0]                   seed;
  modport source (output valid, start_x, start_y, end_x, end_y, step_count, seed,
                  input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, step_count, seed,
                  output ready);
endinterface

interface jbpg_rsp_if #(parameter int COORD_WIDTH = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic [jbpg_pkg::OFS_W-1:0]    offset_us;
  logic [jbpg_pkg::IDX_W-1:0]    point_index;
  logic                          last;
  modport source (output valid, point_x, point_y, offset_us, point_index, last,
                  input ready);
  modport sink   (input valid, point_x, point_y, offset_us, point_index, last,
                  output ready);
endinterface

/* rtl/jbpg_datapath.sv */
// Datapath: request registers, SplitMix64 mixing, shared radix-16 multiplier,
// restoring divider, weight memory and output register.
// Depends on jbpg_pkg.
module jbpg_datapath #(
  parameter int MAX_STEPS   = 63,
  parameter int COORD_WIDTH = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  jbpg_pkg::cmd_t                      cmd_i,
  output jbpg_pkg::sts_t                      sts_o,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [jbpg_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic signed [COORD_WIDTH-1:0]       start_x_i,
  input  logic signed [COORD_WIDTH-1:0]       start_y_i,
  input  logic signed [COORD_WIDTH-1:0]       end_x_i,
  input  logic signed [COORD_WIDTH-1:0]       end_y_i,
  input  logic [jbpg_pkg::IDX_W-1:0]          step_count_i,
  input  logic [63:0]                         seed_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [COORD_WIDTH-1:0]       point_x_o,
  output logic signed [COORD_WIDTH-1:0]       point_y_o,
  output logic [jbpg_pkg::OFS_W-1:0]          offset_us_o,
  output logic [jbpg_pkg::IDX_W-1:0]          point_index_o,
  output logic                                last_o
);

  localparam int W   = COORD_WIDTH;
  localparam int WAW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int MAW = jbpg_pkg::MA_W;
  localparam int MBW = jbpg_pkg::MB_W;
  localparam logic signed [W+1:0] MARGIN = (W+2)'(jbpg_pkg::BOX_MARGIN);
  localparam logic [jbpg_pkg::IDX_W-1:0] NMAX = jbpg_pkg::IDX_W'(MAX_STEPS);

  logic [jbpg_pkg::CFG_W-1:0] min_q, max_q;
  logic [jbpg_pkg::IDX_W-1:0] n_q, i_q, j_q;
  logic                       mul_busy_q, div_busy_q;
  logic [4:0]                 dcnt_q;
  logic                       ov_q;

  logic signed [W-1:0] sx_q, sy_q, ex_q, ey_q, px_q, py_q;
  logic signed [W-1:0] cp_q [4];
  logic [63:0]         rng_q;
  logic [31:0]         u_q;
  logic [jbpg_pkg::OFS_W-1:0] dur_q, run_q;
  logic [jbpg_pkg::TOT_W-1:0] tot_q;
  logic [jbpg_pkg::D3_W-1:0]  d3_q;
  logic [23:0]         p_q;
  logic [jbpg_pkg::D3_W-1:0]  w_q [4];
  logic [MAW-1:0]      ma_q, acc_q;
  logic [MBW-1:0]      mb_q;
  logic [jbpg_pkg::REM_W-1:0] rem_q, dvs_q;
  logic [jbpg_pkg::QUO_W-1:0] dq_q;
  logic [jbpg_pkg::WGT_W-1:0] wmem [MAX_STEPS];
  logic [jbpg_pkg::WGT_W-1:0] wrd_q;
  logic signed [W-1:0] ox_q, oy_q;
  logic [jbpg_pkg::OFS_W-1:0] oofs_q;
  logic [jbpg_pkg::IDX_W-1:0] oidx_q;
  logic                olast_q;

  // SplitMix64 mixing
  logic [63:0] sm_s, sm_z0, sm_z1, sm_z2;
  assign sm_s  = rng_q + jbpg_pkg::SM_GAMMA;
  assign sm_z0 = sm_s ^ (sm_s >> 30);
  assign sm_z1 = acc_q[63:0] ^ (acc_q[63:0] >> 27);
  assign sm_z2 = acc_q[63:0] ^ (acc_q[63:0] >> 31);

  // bounding box
  logic signed [W+1:0] sxe, sye, exe, eye, lo_x, hi_x, lo_y, hi_y, lo_s;
  logic [W+1:0]        span_x, span_y;
  assign sxe = {{2{sx_q[W-1]}}, sx_q};
  assign sye = {{2{sy_q[W-1]}}, sy_q};
  assign exe = {{2{ex_q[W-1]}}, ex_q};
  assign eye = {{2{ey_q[W-1]}}, ey_q};
  assign lo_x = ((sxe < exe) ? sxe : exe) - MARGIN;
  assign hi_x = ((sxe > exe) ? sxe : exe) + MARGIN;
  assign lo_y = ((sye < eye) ? sye : eye) - MARGIN;
  assign hi_y = ((sye > eye) ? sye : eye) + MARGIN;
  assign span_x = hi_x - lo_x;
  assign span_y = hi_y - lo_y;
  assign lo_s = cmd_i.sel[0] ? lo_y : lo_x;

  logic signed [W+2:0] cp_sum;
  logic signed [W-1:0] cp_v;
  always_comb begin
    cp_sum = $signed({lo_s[W+1], lo_s}) + $signed({2'b00, acc_q[32 +: W+1]});
    if (cp_sum > $signed({4'b0000, {(W-1){1'b1}}})) begin
      cp_v = {1'b0, {(W-1){1'b1}}};
    end else if (cp_sum < $signed({4'b1111, {(W-1){1'b0}}})) begin
      cp_v = {1'b1, {(W-1){1'b0}}};
    end else begin
      cp_v = cp_sum[W-1:0];
    end
  end

  // duration
  logic [jbpg_pkg::CFG_W-1:0] dspan;
  logic [jbpg_pkg::OFS_W-1:0] dmul, lo_us;
  assign dspan = (max_q > min_q) ? (max_q - min_q) : '0;
  assign dmul  = jbpg_pkg::OFS_W'(dspan) * jbpg_pkg::OFS_W'(jbpg_pkg::MS_TO_US);
  assign lo_us = jbpg_pkg::OFS_W'(min_q) * jbpg_pkg::OFS_W'(jbpg_pkg::MS_TO_US);

  logic [jbpg_pkg::WGT_W-1:0] wv;
  assign wv = {1'b0, 32'h8000_0000} + {1'b0, u_q};

  // curve parameter
  logic [11:0] den, num, ca, cb;
  logic [6:0]  twon_i;
  assign den    = 12'(n_q) * 12'(n_q);
  assign twon_i = {n_q, 1'b0} - {1'b0, i_q};
  assign num    = 12'(i_q) * 12'(twon_i);
  assign ca     = den - num;
  assign cb     = num;

  logic signed [W-1:0] vraw;
  logic [W-1:0]        vb;
  always_comb begin
    case (cmd_i.sel)
      2'd0:    vraw = cmd_i.axis ? sy_q : sx_q;
      2'd1:    vraw = cp_q[{1'b0, cmd_i.axis}];
      2'd2:    vraw = cp_q[{1'b1, cmd_i.axis}];
      default: vraw = cmd_i.axis ? ey_q : ex_q;
    endcase
  end
  assign vb = {~vraw[W-1], vraw[W-2:0]};

  logic [jbpg_pkg::D3_W-1:0] acc3;
  assign acc3 = acc_q[jbpg_pkg::D3_W-1:0] + {acc_q[jbpg_pkg::D3_W-2:0], 1'b0};

  // multiplier issue
  logic           mul_go, mul_clr;
  logic [MAW-1:0] mul_a;
  logic [MBW-1:0] mul_b;
  always_comb begin
    mul_go  = 1'b1;
    mul_clr = 1'b1;
    mul_a   = '0;
    mul_b   = '0;
    case (cmd_i.op)
      jbpg_pkg::OP_MIX0: begin mul_a = MAW'(sm_z0); mul_b = jbpg_pkg::SM_MIX1; end
      jbpg_pkg::OP_MIX1: begin mul_a = MAW'(sm_z1); mul_b = jbpg_pkg::SM_MIX2; end
      jbpg_pkg::OP_SPAN: begin
        mul_a = MAW'(cmd_i.sel[0] ? span_y : span_x);
        mul_b = MBW'(u_q);
      end
      jbpg_pkg::OP_DUR0: begin mul_a = MAW'(dmul); mul_b = MBW'(u_q); end
      jbpg_pkg::OP_DEN0: begin mul_a = MAW'(den); mul_b = MBW'(den); end
      jbpg_pkg::OP_DEN1: begin mul_a = acc_q; mul_b = MBW'(den); end
      jbpg_pkg::OP_B0:   begin mul_a = MAW'(ca); mul_b = MBW'(ca); end
      jbpg_pkg::OP_B1:   begin mul_a = acc_q; mul_b = MBW'(ca); end
      jbpg_pkg::OP_B2:   begin mul_a = MAW'(p_q); mul_b = MBW'(cb); end
      jbpg_pkg::OP_B3:   begin mul_a = MAW'(cb); mul_b = MBW'(cb); end
      jbpg_pkg::OP_B4:   begin mul_a = acc_q; mul_b = MBW'(cb); end
      jbpg_pkg::OP_B5:   begin mul_a = MAW'(p_q); mul_b = MBW'(ca); end
      jbpg_pkg::OP_SUM:  begin
        mul_a   = MAW'(w_q[cmd_i.sel]);
        mul_b   = MBW'(vb);
        mul_clr = (cmd_i.sel == 2'd0);
      end
      jbpg_pkg::OP_OMUL: begin mul_a = MAW'(wrd_q); mul_b = MBW'(dur_q); end
      default:           mul_go = 1'b0;
    endcase
  end

  logic                       div_go;
  logic [jbpg_pkg::REM_W-1:0] div_dvs;
  assign div_go  = (cmd_i.op == jbpg_pkg::OP_DIVB) || (cmd_i.op == jbpg_pkg::OP_ODIV);
  assign div_dvs = (cmd_i.op == jbpg_pkg::OP_DIVB) ? jbpg_pkg::REM_W'(d3_q)
                                                   : jbpg_pkg::REM_W'(tot_q);

  logic [jbpg_pkg::REM_W:0]   dtry;
  logic                       dge;
  assign dtry = {rem_q, dq_q[jbpg_pkg::QUO_W-1]} - {1'b0, dvs_q};
  assign dge  = ~dtry[jbpg_pkg::REM_W];

  logic [jbpg_pkg::IDX_W-1:0] n_in, i_m1;
  always_comb begin
    if (step_count_i == '0) begin
      n_in = jbpg_pkg::IDX_W'(1);
    end else if (step_count_i > NMAX) begin
      n_in = NMAX;
    end else begin
      n_in = step_count_i;
    end
  end
  assign i_m1 = i_q - jbpg_pkg::IDX_W'(1);

  logic emit;
  assign emit = (cmd_i.op == jbpg_pkg::OP_EMIT);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q      <= jbpg_pkg::MIN_MS_RST;
      max_q      <= jbpg_pkg::MAX_MS_RST;
      n_q        <= '0;
      i_q        <= '0;
      j_q        <= '0;
      mul_busy_q <= 1'b0;
      div_busy_q <= 1'b0;
      dcnt_q     <= '0;
      ov_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          jbpg_pkg::CFG_MIN_IDX: min_q <= cfg_data_i;
          jbpg_pkg::CFG_MAX_IDX: max_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == jbpg_pkg::OP_LOAD) begin
        n_q <= n_in;
        i_q <= '0;
        j_q <= '0;
      end
      if (cmd_i.op == jbpg_pkg::OP_WGT) j_q <= j_q + jbpg_pkg::IDX_W'(1);
      if (emit) i_q <= i_q + jbpg_pkg::IDX_W'(1);
      if (mul_go) begin
        mul_busy_q <= 1'b1;
      end else if (mb_q == '0) begin
        mul_busy_q <= 1'b0;
      end
      if (div_go) begin
        div_busy_q <= 1'b1;
        dcnt_q     <= '0;
      end else if (div_busy_q) begin
        dcnt_q <= dcnt_q + 5'd1;
        if (dcnt_q == 5'd31) div_busy_q <= 1'b0;
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      jbpg_pkg::OP_LOAD: begin
        sx_q  <= start_x_i;
        sy_q  <= start_y_i;
        ex_q  <= end_x_i;
        ey_q  <= end_y_i;
        rng_q <= seed_i;
        tot_q <= '0;
        run_q <= '0;
      end
      jbpg_pkg::OP_MIX0: rng_q <= sm_s;
      jbpg_pkg::OP_MIX2: u_q <= sm_z2[63:32];
      jbpg_pkg::OP_CPW:  cp_q[cmd_i.sel] <= cp_v;
      jbpg_pkg::OP_DUR1: dur_q <= lo_us + acc_q[32 +: jbpg_pkg::OFS_W];
      jbpg_pkg::OP_WGT:  tot_q <= tot_q + jbpg_pkg::TOT_W'(wv);
      jbpg_pkg::OP_DEN2: d3_q <= acc_q[jbpg_pkg::D3_W-1:0];
      jbpg_pkg::OP_B1:   p_q <= acc_q[23:0];
      jbpg_pkg::OP_B2:   w_q[0] <= acc_q[jbpg_pkg::D3_W-1:0];
      jbpg_pkg::OP_B3:   w_q[1] <= acc3;
      jbpg_pkg::OP_B4:   p_q <= acc_q[23:0];
      jbpg_pkg::OP_B5:   w_q[3] <= acc_q[jbpg_pkg::D3_W-1:0];
      jbpg_pkg::OP_B6:   w_q[2] <= acc3;
      jbpg_pkg::OP_PSTO: begin
        if (cmd_i.axis) begin
          py_q <= {~dq_q[W-1], dq_q[W-2:0]};
        end else begin
          px_q <= {~dq_q[W-1], dq_q[W-2:0]};
        end
      end
      jbpg_pkg::OP_OADD: run_q <= run_q + dq_q[jbpg_pkg::OFS_W-1:0];
      default: ;
    endcase

    if (mul_go) begin
      ma_q <= mul_a;
      mb_q <= mul_b;
      if (mul_clr) acc_q <= '0;
    end else if (mul_busy_q && (mb_q != '0)) begin
      acc_q <= acc_q + (ma_q * MAW'(mb_q[3:0]));
      ma_q  <= {ma_q[MAW-5:0], 4'b0000};
      mb_q  <= {4'b0000, mb_q[MBW-1:4]};
    end

    if (div_go) begin
      rem_q <= acc_q[MAW-1:32];
      dq_q  <= acc_q[31:0];
      dvs_q <= div_dvs;
    end else if (div_busy_q) begin
      rem_q <= dge ? dtry[jbpg_pkg::REM_W-1:0]
                   : {rem_q[jbpg_pkg::REM_W-2:0], dq_q[jbpg_pkg::QUO_W-1]};
      dq_q  <= {dq_q[jbpg_pkg::QUO_W-2:0], dge};
    end

    if (emit) begin
      ox_q    <= (i_q == '0) ? sx_q : ((i_q == n_q) ? ex_q : px_q);
      oy_q    <= (i_q == '0) ? sy_q : ((i_q == n_q) ? ey_q : py_q);
      oofs_q  <= (i_q == n_q) ? dur_q : run_q;
      oidx_q  <= i_q;
      olast_q <= (i_q == n_q);
    end
  end

  // weight memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == jbpg_pkg::OP_WGT) wmem[j_q[WAW-1:0]] <= wv;
    wrd_q <= wmem[i_m1[WAW-1:0]];
  end

  assign sts_o.idle     = ~mul_busy_q & ~div_busy_q;
  assign sts_o.out_free = ~ov_q | out_ready_i;
  assign sts_o.i_zero   = (i_q == '0);
  assign sts_o.i_last   = (i_q == n_q);
  assign sts_o.j_last   = (j_q == n_q - jbpg_pkg::IDX_W'(1));

  assign out_valid_o   = ov_q;
  assign point_x_o     = ox_q;
  assign point_y_o     = oy_q;
  assign offset_us_o   = oofs_q;
  assign point_index_o = oidx_q;
  assign last_o        = olast_q;

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_busy_q && div_busy_q)) else $error("multiplier and divider both busy");

  a_div_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_go |-> (acc_q[MAW-1:32] < div_dvs)) else $error("quotient overflow");

  a_weight_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    j_q <= n_q) else $error("weight count beyond step count");

endmodule

/* rtl/jbpg_ctrl.sv */
// Controller: sequences draws, curve weights, divisions and point emission.
// Depends on jbpg_pkg; drives jbpg_datapath through cmd_t, reads sts_t.
module jbpg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  jbpg_pkg::sts_t sts_i,
  output jbpg_pkg::cmd_t cmd_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DRAW0 = 5'd1;
  localparam logic [4:0] S_DRAW1 = 5'd2;
  localparam logic [4:0] S_DRAW2 = 5'd3;
  localparam logic [4:0] S_SPAN  = 5'd4;
  localparam logic [4:0] S_CPW   = 5'd5;
  localparam logic [4:0] S_DUR0  = 5'd6;
  localparam logic [4:0] S_DUR1  = 5'd7;
  localparam logic [4:0] S_WGT   = 5'd8;
  localparam logic [4:0] S_DEN0  = 5'd9;
  localparam logic [4:0] S_DEN1  = 5'd10;
  localparam logic [4:0] S_DEN2  = 5'd11;
  localparam logic [4:0] S_PT    = 5'd12;
  localparam logic [4:0] S_B0    = 5'd13;
  localparam logic [4:0] S_B1    = 5'd14;
  localparam logic [4:0] S_B2    = 5'd15;
  localparam logic [4:0] S_B3    = 5'd16;
  localparam logic [4:0] S_B4    = 5'd17;
  localparam logic [4:0] S_B5    = 5'd18;
  localparam logic [4:0] S_B6    = 5'd19;
  localparam logic [4:0] S_SUM   = 5'd20;
  localparam logic [4:0] S_BDIV  = 5'd21;
  localparam logic [4:0] S_PSTO  = 5'd22;
  localparam logic [4:0] S_O0    = 5'd23;
  localparam logic [4:0] S_O1    = 5'd24;
  localparam logic [4:0] S_O2    = 5'd25;
  localparam logic [4:0] S_EMIT  = 5'd26;

  localparam logic [1:0] P_CP  = 2'd0;
  localparam logic [1:0] P_DUR = 2'd1;
  localparam logic [1:0] P_WGT = 2'd2;

  logic [4:0] state_q, state_d;
  logic [1:0] prp_q, prp_d, k_q, k_d;
  logic       axis_q, axis_d;

  always_comb begin
    state_d    = state_q;
    prp_d      = prp_q;
    k_d        = k_q;
    axis_d     = axis_q;
    cmd_o.op   = jbpg_pkg::OP_NOP;
    cmd_o.sel  = k_q;
    cmd_o.axis = axis_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = jbpg_pkg::OP_LOAD;
          prp_d    = P_CP;
          k_d      = 2'd0;
          state_d  = S_DRAW0;
        end
      end
      S_PT: begin
        k_d    = 2'd0;
        axis_d = 1'b0;
        if (sts_i.i_zero) begin
          state_d = S_EMIT;
        end else if (sts_i.i_last) begin
          state_d = S_O0;
        end else begin
          state_d = S_B0;
        end
      end
      default: begin
        if (sts_i.idle) begin
          case (state_q)
            S_DRAW0: begin cmd_o.op = jbpg_pkg::OP_MIX0; state_d = S_DRAW1; end
            S_DRAW1: begin cmd_o.op = jbpg_pkg::OP_MIX1; state_d = S_DRAW2; end
            S_DRAW2: begin
              cmd_o.op = jbpg_pkg::OP_MIX2;
              case (prp_q)
                P_CP:    state_d = S_SPAN;
                P_DUR:   state_d = S_DUR0;
                default: state_d = S_WGT;
              endcase
            end
            S_SPAN: begin cmd_o.op = jbpg_pkg::OP_SPAN; state_d = S_CPW; end
            S_CPW: begin
              cmd_o.op = jbpg_pkg::OP_CPW;
              k_d      = k_q + 2'd1;
              if (k_q == 2'd3) prp_d = P_DUR;
              state_d = S_DRAW0;
            end
            S_DUR0: begin cmd_o.op = jbpg_pkg::OP_DUR0; state_d = S_DUR1; end
            S_DUR1: begin
              cmd_o.op = jbpg_pkg::OP_DUR1;
              prp_d    = P_WGT;
              state_d  = S_DRAW0;
            end
            S_WGT: begin
              cmd_o.op = jbpg_pkg::OP_WGT;
              state_d  = sts_i.j_last ? S_DEN0 : S_DRAW0;
            end
            S_DEN0: begin cmd_o.op = jbpg_pkg::OP_DEN0; state_d = S_DEN1; end
            S_DEN1: begin cmd_o.op = jbpg_pkg::OP_DEN1; state_d = S_DEN2; end
            S_DEN2: begin cmd_o.op = jbpg_pkg::OP_DEN2; state_d = S_PT; end
            S_B0: begin cmd_o.op = jbpg_pkg::OP_B0; state_d = S_B1; end
            S_B1: begin cmd_o.op = jbpg_pkg::OP_B1; state_d = S_B2; end
            S_B2: begin cmd_o.op = jbpg_pkg::OP_B2; state_d = S_B3; end
            S_B3: begin cmd_o.op = jbpg_pkg::OP_B3; state_d = S_B4; end
            S_B4: begin cmd_o.op = jbpg_pkg::OP_B4; state_d = S_B5; end
            S_B5: begin cmd_o.op = jbpg_pkg::OP_B5; state_d = S_B6; end
            S_B6: begin cmd_o.op = jbpg_pkg::OP_B6; state_d = S_SUM; end
            S_SUM: begin
              cmd_o.op = jbpg_pkg::OP_SUM;
              k_d      = k_q + 2'd1;
              if (k_q == 2'd3) state_d = S_BDIV;
            end
            S_BDIV: begin cmd_o.op = jbpg_pkg::OP_DIVB; state_d = S_PSTO; end
            S_PSTO: begin
              cmd_o.op = jbpg_pkg::OP_PSTO;
              if (!axis_q) begin
                axis_d  = 1'b1;
                state_d = S_SUM;
              end else begin
                state_d = S_O0;
              end
            end
            S_O0: begin cmd_o.op = jbpg_pkg::OP_OMUL; state_d = S_O1; end
            S_O1: begin cmd_o.op = jbpg_pkg::OP_ODIV; state_d = S_O2; end
            S_O2: begin cmd_o.op = jbpg_pkg::OP_OADD; state_d = S_EMIT; end
            S_EMIT: begin
              if (sts_i.out_free) begin
                cmd_o.op = jbpg_pkg::OP_EMIT;
                state_d  = sts_i.i_last ? S_IDLE : S_PT;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      prp_q   <= P_CP;
      k_q     <= 2'd0;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      prp_q   <= prp_d;
      k_q     <= k_d;
      axis_q  <= axis_d;
    end
  end

  a_idle_units_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> sts_i.idle) else $error("unit busy while idle");

endmodule

/* rtl/jittered_bezier_path_generator_unit.sv */
// Each request draws two control points, a duration and per-step weights from a
// SplitMix64 stream, then emits n+1 points of the eased cubic Bezier path with
// time offsets, n being step_count clamped to 1..MAX_STEPS. One request is worked
// at a time; its run time is set by the radix-16 shared multiplier and the
// one-bit-per-cycle divider (three divisions on an inner point, one on the last),
// plus any output stall. A request is taken once the previous one has handed
// its last word to the output register.
// Depends on jbpg_pkg, jbpg_if, jbpg_ctrl and jbpg_datapath.
module jittered_bezier_path_generator_unit #(
  parameter int MAX_STEPS   = 63,
  parameter int COORD_WIDTH = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [jbpg_pkg::CFG_W-1:0] cfg_data_i,
  jbpg_req_if.sink                   req_i,
  jbpg_rsp_if.source                 rsp_o
);

  jbpg_pkg::cmd_t cmd;
  jbpg_pkg::sts_t sts;

  jbpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  jbpg_datapath #(
    .MAX_STEPS   (MAX_STEPS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .start_x_i     (req_i.start_x),
    .start_y_i     (req_i.start_y),
    .end_x_i       (req_i.end_x),
    .end_y_i       (req_i.end_y),
    .step_count_i  (req_i.step_count),
    .seed_i        (req_i.seed),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .point_x_o     (rsp_o.point_x),
    .point_y_o     (rsp_o.point_y),
    .offset_us_o   (rsp_o.offset_us),
    .point_index_o (rsp_o.point_index),
    .last_o        (rsp_o.last)
  );

endmodule
